>>> hw/rtl/wit_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the write admission throttle.
// Used by every module of the block; depends on nothing else.
package wit_pkg;

    localparam int unsigned DEPTH_CAP    = 64;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned TICK_W       = 32;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned PERCENT_MAX  = 100;

    // Reciprocal of 100 scaled by 2^19; exact for dividends below 2^13.
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;

    typedef enum logic [1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DEPTH    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_NOT_ACCT = 2'd1,
        VERDICT_ADMIT    = 2'd2,
        VERDICT_WAIT     = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        WAKE_NONE = 2'd0,
        WAKE_ONE  = 2'd1,
        WAKE_ALL  = 2'd2
    } wake_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRITE_PERCENT  = 2'd0,
        REG_WRITE_CACHE_ON = 2'd1,
        REG_CACHE_DELAY    = 2'd2,
        REG_RECENT_WINDOW  = 2'd3
    } cfg_idx_t;

    localparam logic [6:0]  WRITE_PERCENT_RST = 7'd50;
    localparam logic        WRITE_CACHE_RST   = 1'b0;
    localparam logic [15:0] CACHE_DELAY_RST   = 16'd10;
    localparam logic [15:0] RECENT_WINDOW_RST = 16'd10;

    typedef struct packed {
        logic [6:0]  write_percent;
        logic        write_cache_on;
        logic [15:0] cache_delay_ticks;
        logic [15:0] recent_window_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        is_write;
        logic        is_discard;
        logic        is_sync;
        logic        is_noidle;
        logic        was_counted;
        logic        dirty_waiting;
        logic        waiters_present;
        logic [15:0] queue_depth;
    } item_t;

    // True when tick a lies strictly before tick b, modulo 2^32.
    function automatic logic tick_before(input logic [TICK_W-1:0] a,
                                         input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] diff;
        diff = a - b;
        return diff[TICK_W-1];
    endfunction

    // Quotient of a 13-bit value by 100, through a reciprocal multiply.
    function automatic logic [CNT_W-1:0] div100(input logic [12:0] x);
        logic [25:0] prod;
        prod = 26'(x) * 26'(DIV100_MUL);
        return prod[DIV100_SHIFT +: CNT_W];
    endfunction

endpackage

>>> hw/rtl/writeback_inflight_throttle_unit.sv
`timescale 1ns / 1ps
// Write admission throttle: an accepted input beat passes the input register, then the
// result register, to its result beat. Throughput is one beat per cycle while out_stall
// is low, set by the combinational decision between those two registers.
// Reset clears the in-flight count, the limits (throttling disabled), the tick clock,
// the last-completion time and the delay timer, and loads the register defaults.
// Depends on wit_pkg, wit_cfg_regs, wit_in_stage and wit_core.
module writeback_inflight_throttle_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [wit_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wit_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic                            is_write,
    input  logic                            is_discard,
    input  logic                            is_sync,
    input  logic                            is_noidle,
    input  logic                            was_counted,
    input  logic                            dirty_waiting,
    input  logic                            waiters_present,
    input  logic [15:0]                     queue_depth,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      verdict,
    output logic [1:0]                      wake,
    output logic [wit_pkg::CNT_W-1:0]       inflight_now
);

    wit_pkg::cfg_t  cfg;
    wit_pkg::item_t in_item;
    wit_pkg::item_t item;
    logic           item_valid;
    logic           item_take;

    assign in_item.cmd             = cmd;
    assign in_item.is_write        = is_write;
    assign in_item.is_discard      = is_discard;
    assign in_item.is_sync         = is_sync;
    assign in_item.is_noidle       = is_noidle;
    assign in_item.was_counted     = was_counted;
    assign in_item.dirty_waiting   = dirty_waiting;
    assign in_item.waiters_present = waiters_present;
    assign in_item.queue_depth     = queue_depth;

    wit_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wit_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    wit_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .verdict      (verdict),
        .wake         (wake),
        .inflight_now (inflight_now)
    );

endmodule

>>> hw/rtl/wit_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the write admission throttle.
// Depends on wit_pkg for the register indexes, reset values and cfg_t.
module wit_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [wit_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wit_pkg::CFG_DATA_W-1:0]       cfg_data,
    output wit_pkg::cfg_t                        cfg
);

    wit_pkg::cfg_t cfg_reg;
    wit_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (wit_pkg::cfg_idx_t'(cfg_index))
                wit_pkg::REG_WRITE_PERCENT:  cfg_next.write_percent = cfg_data[6:0];
                wit_pkg::REG_WRITE_CACHE_ON: cfg_next.write_cache_on = cfg_data[0];
                wit_pkg::REG_CACHE_DELAY:    cfg_next.cache_delay_ticks = cfg_data;
                wit_pkg::REG_RECENT_WINDOW:  cfg_next.recent_window_ticks = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_percent       <= wit_pkg::WRITE_PERCENT_RST;
            cfg_reg.write_cache_on      <= wit_pkg::WRITE_CACHE_RST;
            cfg_reg.cache_delay_ticks   <= wit_pkg::CACHE_DELAY_RST;
            cfg_reg.recent_window_ticks <= wit_pkg::RECENT_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/wit_in_stage.sv
`timescale 1ns / 1ps
// Input register of the write admission throttle: holds one accepted beat.
// Depends on wit_pkg for item_t.
module wit_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  wit_pkg::item_t in_item,
    output logic           item_valid,
    output wit_pkg::item_t item,
    input  logic           item_take
);

    logic           valid_reg;
    logic           valid_next;
    wit_pkg::item_t item_reg;
    logic           accept;

    assign in_stall = valid_reg && !item_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hw/rtl/wit_core.sv
`timescale 1ns / 1ps
// Throttle state, admission decision and result register.
// Depends on wit_pkg for types, codes and the tick and divide helpers.
module wit_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wit_pkg::cfg_t                 cfg,
    input  logic                          item_valid,
    input  wit_pkg::item_t                item,
    output logic                          item_take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    verdict,
    output logic [1:0]                    wake,
    output logic [wit_pkg::CNT_W-1:0]     inflight_now
);

    localparam logic [wit_pkg::CNT_W-1:0] CNT_ONE = wit_pkg::CNT_W'(1);
    localparam logic [wit_pkg::CNT_W-1:0] CAP     = wit_pkg::CNT_W'(wit_pkg::DEPTH_CAP);
    localparam logic [6:0]                PCT_MAX = 7'(wit_pkg::PERCENT_MAX);

    logic [wit_pkg::CNT_W-1:0]  inflight_reg, inflight_next;
    logic [wit_pkg::CNT_W-1:0]  limit_max_reg, limit_max_next;
    logic [wit_pkg::CNT_W-1:0]  limit_normal_reg, limit_normal_next;
    logic [wit_pkg::CNT_W-1:0]  limit_idle_reg, limit_idle_next;
    logic [wit_pkg::TICK_W-1:0] now_reg, now_next;
    logic [wit_pkg::TICK_W-1:0] last_reg, last_next;
    logic [wit_pkg::TICK_W-1:0] deadline_reg, deadline_next;
    logic                       armed_reg, armed_next;

    logic                       out_valid_reg, out_valid_next;
    wit_pkg::verdict_t          verdict_reg, verdict_next;
    wit_pkg::wake_t             wake_reg, wake_next;
    logic [wit_pkg::CNT_W-1:0]  inflight_now_reg;

    logic                       fire;
    logic [wit_pkg::CNT_W-1:0]  limit_sel;
    logic [wit_pkg::CNT_W-1:0]  inflight_dec;
    logic [wit_pkg::TICK_W-1:0] now_inc;
    logic [wit_pkg::TICK_W-1:0] delay_ext;
    logic [wit_pkg::TICK_W-1:0] window_ext;
    logic [6:0]                 pct;
    logic [6:0]                 depth_cl;
    logic [12:0]                pd_sum;
    logic [wit_pkg::CNT_W-1:0]  lm;
    logic [7:0]                 lm_half, lm_quarter;

    assign item_take = item_valid && (!out_valid_reg || !out_stall);
    assign fire      = item_take;

    assign delay_ext  = wit_pkg::TICK_W'(cfg.cache_delay_ticks);
    assign window_ext = wit_pkg::TICK_W'(cfg.recent_window_ticks);
    assign now_inc    = now_reg + wit_pkg::TICK_W'(1);

    always_comb
    begin
        inflight_next     = inflight_reg;
        limit_max_next    = limit_max_reg;
        limit_normal_next = limit_normal_reg;
        limit_idle_next   = limit_idle_reg;
        now_next          = now_reg;
        last_next         = last_reg;
        deadline_next     = deadline_reg;
        armed_next        = armed_reg;
        verdict_next      = wit_pkg::VERDICT_NONE;
        wake_next         = wit_pkg::WAKE_NONE;

        if (item.is_sync || item.dirty_waiting)
        begin
            limit_sel = limit_max_reg;
        end
        else if (wit_pkg::tick_before(now_reg, last_reg + window_ext))
        begin
            limit_sel = limit_idle_reg;
        end
        else
        begin
            limit_sel = limit_normal_reg;
        end

        inflight_dec = (inflight_reg != '0) ? inflight_reg - CNT_ONE : '0;

        pct      = (cfg.write_percent > PCT_MAX) ? PCT_MAX : cfg.write_percent;
        depth_cl = (item.queue_depth > 16'(wit_pkg::DEPTH_CAP)) ? CAP : item.queue_depth[6:0];
        pd_sum   = 13'(pct) * 13'(depth_cl) + 13'd1;
        lm       = wit_pkg::div100(pd_sum);
        if (lm == '0 && pct != '0)
        begin
            lm = CNT_ONE;
        end
        lm_half    = (8'(lm) + 8'd1) >> 1;
        lm_quarter = (8'(lm) + 8'd3) >> 2;

        case (wit_pkg::cmd_t'(item.cmd))
            wit_pkg::CMD_SUBMIT:
            begin
                if (limit_normal_reg == '0 || !item.is_write || item.is_discard ||
                    (item.is_sync && !item.is_noidle))
                begin
                    verdict_next = wit_pkg::VERDICT_NOT_ACCT;
                end
                else if (!armed_reg && inflight_reg < limit_sel)
                begin
                    inflight_next = inflight_reg + CNT_ONE;
                    verdict_next  = wit_pkg::VERDICT_ADMIT;
                end
                else
                begin
                    verdict_next = wit_pkg::VERDICT_WAIT;
                end
            end
            wit_pkg::CMD_COMPLETE:
            begin
                if (!item.was_counted)
                begin
                    if (limit_normal_reg != '0)
                    begin
                        last_next = now_reg;
                    end
                end
                else
                begin
                    inflight_next = inflight_dec;
                    if (inflight_dec >= limit_normal_reg)
                    begin
                        wake_next = wit_pkg::WAKE_NONE;
                    end
                    else if (cfg.write_cache_on && !item.dirty_waiting &&
                             wit_pkg::tick_before(now_reg, last_reg + delay_ext))
                    begin
                        if (!armed_reg)
                        begin
                            armed_next    = 1'b1;
                            deadline_next = now_reg + delay_ext;
                        end
                    end
                    else if (item.waiters_present &&
                             (limit_normal_reg - inflight_dec) >= (limit_idle_reg >> 1))
                    begin
                        wake_next = wit_pkg::WAKE_ONE;
                    end
                end
            end
            wit_pkg::CMD_TICK:
            begin
                now_next = now_inc;
                if (armed_reg && !wit_pkg::tick_before(now_inc, deadline_reg))
                begin
                    armed_next = 1'b0;
                    if (item.waiters_present)
                    begin
                        wake_next = wit_pkg::WAKE_ONE;
                    end
                end
            end
            wit_pkg::CMD_DEPTH:
            begin
                limit_max_next    = lm;
                limit_normal_next = lm_half[wit_pkg::CNT_W-1:0];
                limit_idle_next   = lm_quarter[wit_pkg::CNT_W-1:0];
                wake_next         = wit_pkg::WAKE_ALL;
            end
            default:
            begin
                wake_next = wit_pkg::WAKE_NONE;
            end
        endcase
    end

    assign out_valid_next = fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg     <= '0;
            limit_max_reg    <= '0;
            limit_normal_reg <= '0;
            limit_idle_reg   <= '0;
            now_reg          <= '0;
            last_reg         <= '0;
            deadline_reg     <= '0;
            armed_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                inflight_reg     <= inflight_next;
                limit_max_reg    <= limit_max_next;
                limit_normal_reg <= limit_normal_next;
                limit_idle_reg   <= limit_idle_next;
                now_reg          <= now_next;
                last_reg         <= last_next;
                deadline_reg     <= deadline_next;
                armed_reg        <= armed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            verdict_reg      <= verdict_next;
            wake_reg         <= wake_next;
            inflight_now_reg <= inflight_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign wake         = wake_reg;
    assign inflight_now = inflight_now_reg;

    a_inflight_cap: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CAP)
        else $error("in-flight count exceeds the depth cap");

    a_limit_order: assert property (@(posedge clk) disable iff (!rst_n)
        limit_normal_reg <= limit_max_reg && limit_idle_reg <= limit_normal_reg)
        else $error("depth limits out of order");

    a_admit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && verdict_next == wit_pkg::VERDICT_ADMIT |=>
        inflight_reg == $past(inflight_reg) + CNT_ONE)
        else $error("admitted beat did not raise the in-flight count");

    a_verdict_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg != wit_pkg::VERDICT_NONE |->
        wake_reg == wit_pkg::WAKE_NONE)
        else $error("submit result carries a wake-up");

    a_result_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg && inflight_now_reg == inflight_reg)
        else $error("reported count differs from the state");

endmodule
